// ----- sv/fau_pkg.sv -----
package fau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int NUM_W = 2 * OPERAND_WIDTH + 1;
   localparam int DEN_W = 2 * OPERAND_WIDTH;
   localparam int MAG_W = 2 * OPERAND_WIDTH;
   localparam int CNT_W = $clog2(MAG_W);

   typedef enum logic [1:0] {
      ACT_ADD,
      ACT_SUB,
      ACT_MUL,
      ACT_DIV
   } action_type;

   typedef enum logic [1:0] {
      MSEL_FIRST,
      MSEL_SECOND,
      MSEL_DEN
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_REDUCE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      action_type                      action;
      logic signed [OPERAND_WIDTH-1:0] num_a;
      logic signed [OPERAND_WIDTH-1:0] den_a;
      logic signed [OPERAND_WIDTH-1:0] num_b;
      logic signed [OPERAND_WIDTH-1:0] den_b;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] res_num;
      logic signed [DEN_W-1:0] res_den;
      logic                    error;
   } rsp_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        gcd_init;
      logic        gcd_step;
      logic        div_start;
      logic        div_den;
      logic        res_zero_err;
      logic        res_unreduced;
      logic        cap_num;
      logic        cap_den;
      logic        publish;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic skip;
      logic gcd_done;
      logic div_busy;
   } sts_type;

endpackage

// ----- sv/fau_div.sv -----
module fau_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fau_pkg::MAG_W-1:0] dividend,
   input  logic [fau_pkg::MAG_W-1:0] divisor,
   output logic                      busy,
   output logic [fau_pkg::MAG_W-1:0] quotient
);
   import fau_pkg::*;

   localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [MAG_W-1:0] dvs_ff, dvs_in;
   logic [MAG_W:0]   shifted;
   logic [MAG_W+1:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[MAG_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (diff[MAG_W+1]) begin
            rem_in = shifted[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end else begin
            rem_in = diff[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != LAST) |=> busy_ff)
      else $error("divider stopped early");

endmodule

// ----- sv/fau_datapath.sv -----
module fau_datapath (
   input  logic             clock,
   input  logic             reset,
   input  fau_pkg::req_type req_payload,
   input  fau_pkg::cmd_type cmd,
   output fau_pkg::sts_type sts,
   output fau_pkg::rsp_type rsp_payload
);
   import fau_pkg::*;

   req_type                         req_ff, req_in;
   logic                            err_ff, err_in;
   logic signed [NUM_W-1:0]         num_ff, num_in;
   logic signed [DEN_W-1:0]         den_ff, den_in;
   logic [MAG_W-1:0]                ga_ff, ga_in, gb_ff, gb_in;
   logic [MAG_W-1:0]                qa_ff, qa_in, qb_ff, qb_in;
   logic signed [NUM_W-1:0]         res_num_ff, res_num_in;
   logic signed [DEN_W-1:0]         res_den_ff, res_den_in;
   logic                            res_err_ff, res_err_in;
   rsp_type                         rsp_ff, rsp_in;
   logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
   logic signed [DEN_W-1:0]         prod;
   logic [MAG_W-1:0]                mag_num, mag_den, g_val;
   logic [MAG_W-1:0]                div_dividend, div_quotient;
   logic                            div_busy;
   logic [NUM_W-1:0]                qn;
   logic [DEN_W-1:0]                qd;

   always_comb begin
      unique case (cmd.mul_sel)
         MSEL_FIRST: begin
            mul_x = req_ff.num_a;
            mul_y = (req_ff.action == ACT_MUL) ? req_ff.num_b : req_ff.den_b;
         end
         MSEL_SECOND: begin
            mul_x = req_ff.num_b;
            mul_y = req_ff.den_a;
         end
         default: begin
            mul_x = req_ff.den_a;
            mul_y = (req_ff.action == ACT_DIV) ? req_ff.num_b : req_ff.den_b;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   assign mag_num = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   assign mag_den = den_ff[DEN_W-1] ? MAG_W'(-den_ff) : MAG_W'(den_ff);
   assign g_val   = (gb_ff != '0) ? gb_ff : ((ga_ff != '0) ? ga_ff : MAG_W'(1));
   assign div_dividend = cmd.div_den ? qb_ff : qa_ff;

   fau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (g_val),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign qn = NUM_W'(div_quotient);
   assign qd = DEN_W'(div_quotient);

   always_comb begin
      req_in = req_ff;
      err_in = err_ff;
      if (cmd.load) begin
         req_in = req_payload;
         err_in = (req_payload.den_a == '0) || (req_payload.den_b == '0) ||
                  ((req_payload.action == ACT_DIV) && (req_payload.num_b == '0));
      end

      num_in = num_ff;
      den_in = den_ff;
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            MSEL_FIRST: num_in = NUM_W'(prod);
            MSEL_SECOND: begin
               if (req_ff.action == ACT_ADD) begin
                  num_in = num_ff + NUM_W'(prod);
               end else if (req_ff.action == ACT_SUB) begin
                  num_in = num_ff - NUM_W'(prod);
               end
            end
            default: den_in = prod;
         endcase
      end

      ga_in = ga_ff;
      gb_in = gb_ff;
      qa_in = qa_ff;
      qb_in = qb_ff;
      if (cmd.gcd_init) begin
         ga_in = mag_num;
         gb_in = mag_den;
         qa_in = mag_num;
         qb_in = mag_den;
      end else if (cmd.gcd_step) begin
         priority if (!ga_ff[0] && !gb_ff[0]) begin
            ga_in = ga_ff >> 1;
            gb_in = gb_ff >> 1;
            qa_in = qa_ff >> 1;
            qb_in = qb_ff >> 1;
         end else if (!ga_ff[0]) begin
            ga_in = ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_in = gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_in = (ga_ff - gb_ff) >> 1;
         end else begin
            gb_in = (gb_ff - ga_ff) >> 1;
         end
      end

      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      res_err_in = res_err_ff;
      if (cmd.res_zero_err) begin
         res_num_in = '0;
         res_den_in = '0;
         res_err_in = 1'b1;
      end else if (cmd.res_unreduced) begin
         res_num_in = '0;
         res_den_in = den_ff;
         res_err_in = 1'b0;
      end else begin
         if (cmd.cap_num) begin
            res_num_in = $signed(num_ff[NUM_W-1] ? (~qn + 1'b1) : qn);
            res_err_in = 1'b0;
         end
         if (cmd.cap_den) begin
            res_den_in = $signed(den_ff[DEN_W-1] ? (~qd + 1'b1) : qd);
         end
      end

      rsp_in = rsp_ff;
      if (cmd.publish) begin
         rsp_in.res_num = res_num_ff;
         rsp_in.res_den = res_den_ff;
         rsp_in.error   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      err_ff     <= err_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      qa_ff      <= qa_in;
      qb_ff      <= qb_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_err_ff <= res_err_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.err      = err_ff;
   assign sts.skip     = (req_ff.action == ACT_SUB) && (num_ff == '0);
   assign sts.gcd_done = (ga_ff == '0) || (gb_ff == '0);
   assign sts.div_busy = div_busy;
   assign rsp_payload  = rsp_ff;

   a_gcd_live: assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> (ga_ff != '0) && (gb_ff != '0))
      else $error("gcd step issued after completion");

endmodule

// ----- sv/fau_ctrl.sv -----
module fau_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  fau_pkg::sts_type sts,
   output fau_pkg::cmd_type cmd
);
   import fau_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (sts.err) begin
               cmd.res_zero_err = 1'b1;
               state_in         = ST_FINISH;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MSEL_FIRST;
               state_in    = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_SECOND;
            state_in    = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_DEN;
            state_in    = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (sts.skip) begin
               cmd.res_unreduced = 1'b1;
               state_in          = ST_FINISH;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_NUM;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_NUM: begin
            if (!sts.div_busy) begin
               cmd.cap_num   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_den   = 1'b1;
               state_in      = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (!sts.div_busy) begin
               cmd.cap_den = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten before taken");

   a_error_bypass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_A && sts.err) |=> state_ff == ST_FINISH)
      else $error("error item entered the datapath");

endmodule

// ----- sv/fraction_arithmetic_unit.sv -----
// Exact add, subtract, multiply or divide of two signed fractions, reduced by
// the GCD of the magnitudes of the result numerator and denominator.
// Request channel (req_valid/req_ready/req_payload): one beat carries the
// operation and both fractions. Response channel (rsp_valid/rsp_ready/
// rsp_payload): one beat per request with the numerator, the denominator and
// an error flag; signs are kept as the cross products give them.
// Flow: one shared multiplier forms the three products in turn, a binary GCD
// loop then runs until one of its values reaches zero, and one restoring
// divider runs twice, for the numerator and then for the denominator. An error
// item skips straight to the result, as does a subtraction whose difference is
// zero, which is left unreduced. One item is in flight at a time; the next
// request is taken the cycle after the result is loaded into the output
// register.
// Reset clears the controller and drops any pending response. If the receiver
// stalls, the response holds in its register and the unit accepts one more
// request, then waits with that result ready until the register frees.
module fraction_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fau_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fau_pkg::rsp_type rsp_payload
);
   import fau_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fau_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule
